FILE: src/error_diffusion_dither_top_assert.svh
// ----------------------------------------------------------------------------
// Error diffusion dither assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_DITHER_TOP_ASSERT_SVH
`define ERROR_DIFFUSION_DITHER_TOP_ASSERT_SVH

// same-cycle implication
`define EDD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EDD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/edd_pkg.sv
// ----------------------------------------------------------------------------
// edd_pkg
// Widths, register indexes and arithmetic helpers of the error diffusion dither.
// ----------------------------------------------------------------------------
package edd_pkg;

   localparam int PIX_W       = 8;
   localparam int LINE_W_W    = 11;
   localparam int THR_W       = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int NUM_CH      = 3;

   localparam int ERR_ROW_W   = 9;   // next-row error, |e| <= 144
   localparam int ERR_CARRY_W = 10;  // right carry, |e| <= 112
   localparam int SUM_W       = 12;  // raw corrected sum
   localparam int V_W         = 11;  // saturated corrected value
   localparam int E_W         = 10;  // quantization error, -256..256
   localparam int PROD_W      = 14;
   localparam int V_MIN       = -256;
   localparam int V_MAX       = 511;

   localparam logic [PIX_W-1:0] PIX_FULL = 8'hFF;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd1;

   localparam logic [LINE_W_W-1:0] LINE_WIDTH_RST = 11'd640;
   localparam logic [THR_W-1:0]    THRESHOLD_RST  = 8'd128;

   localparam logic [2:0] K_RIGHT      = 3'd7;
   localparam logic [2:0] K_BELOW_LEFT = 3'd3;
   localparam logic [2:0] K_BELOW      = 3'd5;
   localparam logic [2:0] K_BELOW_RGT  = 3'd1;

   function automatic logic signed [V_W-1:0] saturate_corrected(
      input logic signed [SUM_W-1:0] s);
      logic signed [V_W-1:0] r;
      if (s < V_MIN) begin
         r = V_W'(V_MIN);
      end else if (s > V_MAX) begin
         r = V_W'(V_MAX);
      end else begin
         r = V_W'(s);
      end
      return r;
   endfunction

   // (e * k) / 16, truncated toward zero
   function automatic logic signed [ERR_CARRY_W-1:0] diffuse_term(
      input logic signed [E_W-1:0] e, input logic [2:0] k);
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(e) * PROD_W'($signed({1'b0, k}));
      if (p < 0) begin
         p = p + PROD_W'(15);
      end
      p = p >>> 4;
      return ERR_CARRY_W'(p);
   endfunction

endpackage

FILE: src/edd_channels_if.sv
// ----------------------------------------------------------------------------
// Error diffusion dither channels
// Valid/ready pixel request channel and dithered response channel.
// ----------------------------------------------------------------------------
interface edd_req_if import edd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             frame_start;
   logic [PIX_W-1:0] pixel_ch0;
   logic [PIX_W-1:0] pixel_ch1;
   logic [PIX_W-1:0] pixel_ch2;

   modport source(output valid, frame_start, pixel_ch0, pixel_ch1, pixel_ch2,
                  input ready);
   modport sink(input valid, frame_start, pixel_ch0, pixel_ch1, pixel_ch2,
                output ready);
endinterface

interface edd_rsp_if import edd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_ch0;
   logic [PIX_W-1:0] out_ch1;
   logic [PIX_W-1:0] out_ch2;
   logic             line_end;

   modport source(output valid, out_ch0, out_ch1, out_ch2, line_end,
                  input ready);
   modport sink(input valid, out_ch0, out_ch1, out_ch2, line_end,
                output ready);
endinterface

FILE: src/error_diffusion_dither_top.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither_top
// 1-bit error diffusion dither of three 8-bit channels, raster order.
// ----------------------------------------------------------------------------
// Pixels enter on req_chan in raster order, frame_start on the first pixel of
// a frame. Each accepted pixel gives one transfer on rsp_chan: the three
// channels quantized to 0 or 255 and line_end on the last pixel of a line.
// line_width and threshold are written through csr_*; the user must write
// them only while no pixel is in flight; the block does not enforce this.
// Throughput is one pixel per clock unless rsp_chan stalls. A result passes the
// error-stage registers (line-store read registered with the pixel), then the
// error datapath into the output register. The line store is one synchronous
// RAM of MAX_LINE_WIDTH words with one write and one read per cycle; the last
// column of a line is written in the cycle after that pixel, and in-flight
// writes are forwarded to the reader. Synchronous reset empties the pipeline,
// clears the running error, sets the first-row state and reloads the registers
// (640 pixels, threshold 128); the line store is not cleared. When rsp_chan
// stalls the output register holds, the error stage holds behind it and
// req_chan.ready drops once both are full.
// ----------------------------------------------------------------------------
module error_diffusion_dither_top
   import edd_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = 1024
)
(
   input  logic                  clock,
   input  logic                  reset,
   edd_req_if.sink               req_chan,
   edd_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "error_diffusion_dither_top_assert.svh"

   localparam int COL_W = $clog2(MAX_LINE_WIDTH);
   localparam int EXT_W = (COL_W + 1 > LINE_W_W) ? COL_W + 1 : LINE_W_W;
   localparam int ROW_W = NUM_CH * ERR_ROW_W;

   // configuration
   logic [LINE_W_W-1:0] line_width_ff;
   logic [THR_W-1:0]    threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RST;
         threshold_ff  <= THRESHOLD_RST;
      end else if (csr_we) begin
         if (csr_index == CSR_LINE_WIDTH) begin
            line_width_ff <= csr_wdata[LINE_W_W-1:0];
         end else if (csr_index == CSR_THRESHOLD) begin
            threshold_ff <= csr_wdata[THR_W-1:0];
         end
      end
   end

   // handshake
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic s1_adv;
   logic req_fire;

   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // column tracking at accept
   logic [EXT_W-1:0] width_eff;
   logic [COL_W-1:0] col_ff, col_in, acc_col;
   logic             first_ff, first_in, acc_first, acc_last;

   always_comb begin
      width_eff = EXT_W'(line_width_ff);
      if (width_eff == '0) begin
         width_eff = EXT_W'(1);
      end else if (width_eff > EXT_W'(MAX_LINE_WIDTH)) begin
         width_eff = EXT_W'(MAX_LINE_WIDTH);
      end
      acc_col   = req_chan.frame_start ? '0 : col_ff;
      acc_first = req_chan.frame_start || first_ff;
      acc_last  = (EXT_W'(acc_col) + EXT_W'(1)) >= width_eff;
      col_in    = acc_last ? '0 : COL_W'(acc_col + COL_W'(1));
      first_in  = acc_first && !acc_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         first_ff <= 1'b1;
      end else if (req_fire) begin
         col_ff   <= col_in;
         first_ff <= first_in;
      end
   end

   // error stage registers
   logic             s1_fs_ff, s1_first_ff, s1_last_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [PIX_W-1:0] s1_pix_ff [NUM_CH];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_fs_ff     <= req_chan.frame_start;
         s1_first_ff  <= acc_first;
         s1_last_ff   <= acc_last;
         s1_col_ff    <= acc_col;
         s1_pix_ff[0] <= req_chan.pixel_ch0;
         s1_pix_ff[1] <= req_chan.pixel_ch1;
         s1_pix_ff[2] <= req_chan.pixel_ch2;
      end
   end

   // line store
   logic [ROW_W-1:0] row_mem [MAX_LINE_WIDTH];
   logic [ROW_W-1:0] rd_data_ff;
   logic             wr_en;
   logic [COL_W-1:0] wr_addr;
   logic [ROW_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= row_mem[acc_col];
      end
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
   end

   // last-column write, deferred to the following cycle
   logic             defer_valid_ff;
   logic [COL_W-1:0] defer_addr_ff;
   logic [ROW_W-1:0] defer_data_ff;

   // forwarding for the stage-1 read
   logic             ovr_valid_ff;
   logic [ROW_W-1:0] ovr_data_ff;
   logic [ROW_W-1:0] above_row;
   logic             defer_hit;

   assign defer_hit = defer_valid_ff && (defer_addr_ff == s1_col_ff);

   always_comb begin
      if (defer_hit) begin
         above_row = defer_data_ff;
      end else if (ovr_valid_ff) begin
         above_row = ovr_data_ff;
      end else begin
         above_row = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovr_valid_ff <= 1'b0;
      end else if (req_fire) begin
         ovr_valid_ff <= wr_en && (wr_addr == acc_col);
      end else if (s1_valid_ff && !s1_adv) begin
         ovr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ovr_data_ff <= wr_data;
      end else if (s1_valid_ff && !s1_adv) begin
         ovr_data_ff <= above_row;
      end
   end

   // running error
   logic signed [ERR_CARRY_W-1:0] rc_ff  [NUM_CH];
   logic signed [ERR_ROW_W-1:0]   pbl_ff [NUM_CH];
   logic signed [ERR_ROW_W-1:0]   pb_ff  [NUM_CH];

   // datapath
   logic signed [ERR_CARRY_W-1:0] rc_use    [NUM_CH];
   logic signed [ERR_ROW_W-1:0]   pbl_use   [NUM_CH];
   logic signed [ERR_ROW_W-1:0]   pb_use    [NUM_CH];
   logic signed [ERR_ROW_W-1:0]   above     [NUM_CH];
   logic signed [SUM_W-1:0]       sum_raw   [NUM_CH];
   logic signed [V_W-1:0]         corr      [NUM_CH];
   logic                          q_hi      [NUM_CH];
   logic signed [E_W-1:0]         err       [NUM_CH];
   logic signed [ERR_CARRY_W-1:0] t7        [NUM_CH];
   logic signed [ERR_ROW_W-1:0]   t3        [NUM_CH];
   logic signed [ERR_ROW_W-1:0]   t5        [NUM_CH];
   logic signed [ERR_ROW_W-1:0]   t1        [NUM_CH];
   logic signed [ERR_ROW_W-1:0]   left_sum  [NUM_CH];
   logic [ROW_W-1:0]              bl_row;
   logic [ROW_W-1:0]              tail_row;
   logic signed [V_W-1:0]         thr_s;

   always_comb begin
      thr_s    = $signed({3'b000, threshold_ff});
      bl_row   = '0;
      tail_row = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         rc_use[ch]  = s1_fs_ff ? '0 : rc_ff[ch];
         pbl_use[ch] = s1_fs_ff ? '0 : pbl_ff[ch];
         pb_use[ch]  = s1_fs_ff ? '0 : pb_ff[ch];
         above[ch]   = s1_first_ff ? '0 : $signed(above_row[ch*ERR_ROW_W +: ERR_ROW_W]);
         sum_raw[ch] = $signed({4'b0000, s1_pix_ff[ch]}) + SUM_W'(rc_use[ch])
                       + SUM_W'(above[ch]);
         corr[ch]    = saturate_corrected(sum_raw[ch]);
         q_hi[ch]    = corr[ch] >= thr_s;
         err[ch]     = E_W'(corr[ch] - (q_hi[ch] ? $signed({3'b000, PIX_FULL})
                                                 : V_W'(0)));
         t7[ch]       = diffuse_term(err[ch], K_RIGHT);
         t3[ch]       = ERR_ROW_W'(diffuse_term(err[ch], K_BELOW_LEFT));
         t5[ch]       = ERR_ROW_W'(diffuse_term(err[ch], K_BELOW));
         t1[ch]       = ERR_ROW_W'(diffuse_term(err[ch], K_BELOW_RGT));
         left_sum[ch] = pb_use[ch] + t5[ch];
         bl_row[ch*ERR_ROW_W +: ERR_ROW_W]   = pbl_use[ch] + t3[ch];
         tail_row[ch*ERR_ROW_W +: ERR_ROW_W] = left_sum[ch];
      end
   end

   logic s1_wr;
   assign s1_wr = s1_adv && (s1_col_ff != '0);

   always_comb begin
      if (defer_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = defer_addr_ff;
         wr_data = defer_data_ff;
      end else begin
         wr_en   = s1_wr;
         wr_addr = COL_W'(s1_col_ff - COL_W'(1));
         wr_data = bl_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         defer_valid_ff <= 1'b0;
      end else begin
         defer_valid_ff <= s1_adv && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_last_ff) begin
         defer_addr_ff <= s1_col_ff;
         defer_data_ff <= tail_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            rc_ff[ch]  <= '0;
            pbl_ff[ch] <= '0;
            pb_ff[ch]  <= '0;
         end
      end else if (s1_adv) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            if (s1_last_ff) begin
               rc_ff[ch]  <= '0;
               pbl_ff[ch] <= '0;
               pb_ff[ch]  <= '0;
            end else begin
               rc_ff[ch]  <= t7[ch];
               pbl_ff[ch] <= left_sum[ch];
               pb_ff[ch]  <= t1[ch];
            end
         end
      end
   end

   // output register
   logic [PIX_W-1:0] out_ff [NUM_CH];
   logic             line_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            out_ff[ch] <= q_hi[ch] ? PIX_FULL : '0;
         end
         line_end_ff <= s1_last_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_ch0  = out_ff[0];
   assign rsp_chan.out_ch1  = out_ff[1];
   assign rsp_chan.out_ch2  = out_ff[2];
   assign rsp_chan.line_end = line_end_ff;

   // checks
   `EDD_ASSERT_NOW(a_wr_port_free, defer_valid_ff, !s1_wr, "line store write collision")
   `EDD_ASSERT_NEXT(a_defer_follows_last, s1_adv && s1_last_ff, defer_valid_ff, "tail write lost")
   `EDD_ASSERT_NOW(a_col_in_range, 1'b1, EXT_W'(col_ff) < EXT_W'(MAX_LINE_WIDTH), "column overrun")
   `EDD_ASSERT_NOW(a_accept_frees_stage, req_fire && s1_valid_ff, s1_adv, "stage overwritten")

endmodule
